// File: rtl/sgw_pkg.sv
`timescale 1ns / 1ps
package sgw_pkg;

  localparam int LEVEL_W = 26;
  localparam int PEAK_W  = 6;
  localparam int TICK_W  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int AMOUNT_W = 8;
  localparam int PHASE_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_ENABLE       = 3'd0,
    CFG_USB_MOUSE_ENABLE   = 3'd1,
    CFG_LOW_ENTER_LEVEL    = 3'd2,
    CFG_HIGH_ENTER_LEVEL   = 3'd3,
    CFG_LOW_RECOVER_LEVEL  = 3'd4,
    CFG_HIGH_HOLD_LEVEL    = 3'd5,
    CFG_HIGH_RELEASE_LEVEL = 3'd6
  } cfg_idx_t;

  localparam logic [LEVEL_W-1:0] LOW_ENTER_RESET    = 26'd300000;
  localparam logic [LEVEL_W-1:0] HIGH_ENTER_RESET   = 26'd5000000;
  localparam logic [LEVEL_W-1:0] LOW_RECOVER_RESET  = 26'd2000000;
  localparam logic [LEVEL_W-1:0] HIGH_HOLD_RESET    = 26'd3000000;
  localparam logic [LEVEL_W-1:0] HIGH_RELEASE_RESET = 26'd500000;

  // Peak excess = (mag - EXCESS_BASE) / 1e6, saturating at PEAK_MAX.
  // Division by 1e6 is a multiply by ceil(2^46 / 1e6), exact for d < 2^26.
  localparam logic [LEVEL_W-1:0] EXCESS_BASE  = 26'd1700000;
  localparam logic [LEVEL_W-1:0] EXCESS_SAT   = 26'd64000000;
  localparam int                 RECIP_W      = 27;
  localparam logic [RECIP_W-1:0] EXCESS_RECIP = 27'd70368745;
  localparam int                 RECIP_SHIFT  = 46;
  localparam logic [PEAK_W-1:0]  PEAK_MAX     = 6'd63;
  localparam logic [PEAK_W-1:0]  PEAK_START   = 6'd1;

  localparam logic [TICK_W-1:0] TICKS_LOW    = 7'd20;
  localparam logic [TICK_W-1:0] TICKS_LOWREC = 7'd30;
  localparam logic [TICK_W-1:0] TICKS_WAIT   = 7'd60;
  localparam logic [TICK_W-1:0] TICKS_HIGH   = 7'd90;

  localparam logic [PEAK_W-1:0] QUANT_SMALL_LIMIT = 6'd6;
  localparam logic [PEAK_W-1:0] QUANT_MID_LIMIT   = 6'd12;
  localparam logic [PEAK_W-1:0] QUANT_SMALL       = 6'd1;
  localparam logic [PEAK_W-1:0] QUANT_MID         = 6'd4;

  localparam logic [PHASE_W-1:0] PHASE_CODE_WAIT = 3'd4;

  typedef struct packed {
    logic               wheel_enable;
    logic               usb_mouse_enable;
    logic [LEVEL_W-1:0] low_enter_level;
    logic [LEVEL_W-1:0] high_enter_level;
    logic [LEVEL_W-1:0] low_recover_level;
    logic [LEVEL_W-1:0] high_hold_level;
    logic [LEVEL_W-1:0] high_release_level;
  } sgw_cfg_t;

  typedef struct packed {
    logic lt_low_enter;
    logic gt_high_enter;
    logic gt_low_recover;
    logic gt_high_hold;
    logic lt_high_release;
    logic over_base;
  } sgw_cmp_t;

  typedef struct packed {
    logic              host;
    sgw_cmp_t          cmp;
    logic [PEAK_W-1:0] excess;
  } sgw_meas_t;

endpackage

// File: rtl/sgw_sample_if.sv
`timescale 1ns / 1ps
interface sgw_sample_if #(
  parameter int SAMPLE_BITS = 13
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;
  logic                          host_present;

  modport source (output valid, accel_x, accel_y, accel_z, host_present, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, host_present, output ready);
endinterface

// File: rtl/sgw_result_if.sv
`timescale 1ns / 1ps
interface sgw_result_if;
  logic              valid;
  logic              ready;
  logic              wheel_valid;
  logic signed [7:0] wheel_amount;
  logic [2:0]        gesture_phase;

  modport source (output valid, wheel_valid, wheel_amount, gesture_phase, input ready);
  modport sink   (input valid, wheel_valid, wheel_amount, gesture_phase, output ready);
endinterface

// File: rtl/sgw_square_lane.sv
`timescale 1ns / 1ps
module sgw_square_lane #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] axis,
  output logic [2*SAMPLE_BITS-1:0]      square
);

  logic signed [2*SAMPLE_BITS-1:0] product;

  assign product = axis * axis;

  always_ff @(posedge clk) begin
    if (load) begin
      square <= product;
    end
  end

endmodule

// File: rtl/sgw_merge.sv
`timescale 1ns / 1ps
module sgw_merge import sgw_pkg::*; #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sgw_cfg_t                 cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_host,
  input  logic [2*SAMPLE_BITS-1:0] sq_x,
  input  logic [2*SAMPLE_BITS-1:0] sq_y,
  input  logic [2*SAMPLE_BITS-1:0] sq_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output sgw_meas_t                meas
);

  // Sum of three squares fits in 2*SAMPLE_BITS bits.
  localparam int MAG_BITS = 2 * SAMPLE_BITS;
  localparam int CMP_BITS = (MAG_BITS > LEVEL_W) ? MAG_BITS : LEVEL_W;
  localparam int PROD_W   = LEVEL_W + RECIP_W;

  logic                v2, v3, v4;
  logic                rdy2, rdy3, rdy4;
  logic                host2, host3;
  logic [MAG_BITS-1:0] mag;
  logic [LEVEL_W-1:0]  diff;
  logic                sat;
  sgw_cmp_t            cmp3;
  sgw_meas_t           meas4;

  logic [CMP_BITS-1:0] mag_ext;
  logic [CMP_BITS-1:0] diff_full;
  sgw_cmp_t            cmp_now;
  logic [PROD_W-1:0]   prod;
  logic [PEAK_W-1:0]   quot;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign in_ready = rdy2;

  assign out_valid = v4;
  assign meas      = meas4;

  always_comb begin
    mag_ext   = CMP_BITS'(mag);
    diff_full = mag_ext - CMP_BITS'(EXCESS_BASE);
    cmp_now.lt_low_enter    = mag_ext < CMP_BITS'(cfg.low_enter_level);
    cmp_now.gt_high_enter   = mag_ext > CMP_BITS'(cfg.high_enter_level);
    cmp_now.gt_low_recover  = mag_ext > CMP_BITS'(cfg.low_recover_level);
    cmp_now.gt_high_hold    = mag_ext > CMP_BITS'(cfg.high_hold_level);
    cmp_now.lt_high_release = mag_ext < CMP_BITS'(cfg.high_release_level);
    cmp_now.over_base       = mag_ext > CMP_BITS'(EXCESS_BASE);
  end

  assign prod = PROD_W'(diff) * PROD_W'(EXCESS_RECIP);
  assign quot = prod[RECIP_SHIFT +: PEAK_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy2) v2 <= in_valid;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      host2 <= in_host;
      mag   <= sq_x + sq_y + sq_z;
    end
    if (rdy3) begin
      host3 <= host2;
      cmp3  <= cmp_now;
      sat   <= diff_full >= CMP_BITS'(EXCESS_SAT);
      diff  <= diff_full[LEVEL_W-1:0];
    end
    if (rdy4) begin
      meas4.host   <= host3;
      meas4.cmp    <= cmp3;
      meas4.excess <= sat ? PEAK_MAX : quot;
    end
  end

endmodule

// File: rtl/sgw_gesture_fsm.sv
`timescale 1ns / 1ps
module sgw_gesture_fsm import sgw_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  sgw_cfg_t                   cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sgw_meas_t                  meas,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       wheel_valid,
  output logic signed [AMOUNT_W-1:0] wheel_amount,
  output logic [PHASE_W-1:0]         gesture_phase
);

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_LOW    = 3'd1,
    PH_LOWREC = 3'd2,
    PH_HIGH   = 3'd3,
    PH_WAIT   = 3'd4
  } phase_t;

  phase_t             phase, phase_next;
  logic [TICK_W-1:0]  ticks, ticks_next;
  logic [PEAK_W-1:0]  peak, peak_next;
  logic               step;
  logic               step_neg;
  logic               active;
  logic [PEAK_W-1:0]  quant;
  logic [PEAK_W-1:0]  tracked;
  logic [AMOUNT_W-1:0] mag_amount;
  logic [AMOUNT_W-1:0] amount_next;

  assign in_ready = !out_valid || out_ready;
  assign active   = meas.host && cfg.usb_mouse_enable && cfg.wheel_enable;

  always_comb begin
    if (peak < QUANT_SMALL_LIMIT) begin
      quant = QUANT_SMALL;
    end else if (peak < QUANT_MID_LIMIT) begin
      quant = QUANT_MID;
    end else begin
      quant = peak;
    end
    mag_amount  = AMOUNT_W'(quant);
    tracked     = (meas.cmp.over_base && (meas.excess > peak)) ? meas.excess : peak;
  end

  always_comb begin
    phase_next = phase;
    ticks_next = ticks;
    peak_next  = peak;
    step       = 1'b0;
    step_neg   = 1'b0;
    if (active) begin
      case (phase)
        PH_IDLE: begin
          if (meas.cmp.lt_low_enter) begin
            phase_next = PH_LOW;
            peak_next  = PEAK_START;
            ticks_next = TICKS_LOW;
          end else if (meas.cmp.gt_high_enter) begin
            phase_next = PH_HIGH;
            peak_next  = PEAK_START;
            ticks_next = TICKS_HIGH;
          end
        end
        PH_LOW: begin
          if (meas.cmp.gt_low_recover) begin
            phase_next = PH_LOWREC;
            ticks_next = TICKS_LOWREC;
          end else if (meas.cmp.lt_low_enter) begin
            ticks_next = TICKS_LOW;
          end
        end
        PH_LOWREC: begin
          // window closes on this sample: report the dip
          if (ticks == TICK_W'(1)) begin
            step       = 1'b1;
            step_neg   = 1'b1;
            phase_next = PH_WAIT;
            ticks_next = TICKS_WAIT;
          end else begin
            peak_next = tracked;
          end
        end
        PH_HIGH: begin
          if (meas.cmp.gt_high_hold) begin
            peak_next = tracked;
          end else if (meas.cmp.lt_high_release) begin
            step       = 1'b1;
            phase_next = PH_WAIT;
            ticks_next = TICKS_WAIT;
          end
        end
        default: begin
        end
      endcase
      if (ticks_next != '0) begin
        ticks_next = ticks_next - TICK_W'(1);
        if (ticks_next == '0) begin
          phase_next = PH_IDLE;
        end
      end
    end
    if (!step) begin
      amount_next = '0;
    end else if (step_neg) begin
      amount_next = -mag_amount;
    end else begin
      amount_next = mag_amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      ticks         <= '0;
      peak          <= '0;
      out_valid     <= 1'b0;
      wheel_valid   <= 1'b0;
      wheel_amount  <= '0;
      gesture_phase <= '0;
    end else if (in_valid && in_ready) begin
      phase         <= phase_next;
      ticks         <= ticks_next;
      peak          <= peak_next;
      out_valid     <= 1'b1;
      wheel_valid   <= step;
      wheel_amount  <= amount_next;
      gesture_phase <= phase_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/shake_gesture_wheel_detector_top.sv
`timescale 1ns / 1ps
// Shake-wheel gesture detector. Each accepted accelerometer sample yields exactly one
// result on the result channel, and one sample can be taken in every cycle while the
// result channel is not stalled. Three squaring lanes work on x, y and z in parallel; a
// merge pipeline sums the squares, compares the magnitude against the five level
// registers and forms the peak excess with a reciprocal multiply; the gesture state
// machine in the last stage sees the state left by the previous sample, which sets the
// one-sample-per-cycle rate.
// A dip then recovery reports a negative step when the recovery window ends; a spike then
// release reports a positive step. Samples with host_present low, or with either enable
// register clear, leave the state untouched and report the current phase.
// Write configuration only while no sample is in flight.
module shake_gesture_wheel_detector_top import sgw_pkg::*; #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  sgw_sample_if.sink           sample,
  sgw_result_if.source         result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_data
);

  localparam int SQ_W = 2 * SAMPLE_BITS;

  sgw_cfg_t        cfg;
  logic            v1;
  logic            rdy1;
  logic            host1;
  logic [SQ_W-1:0] sq_x, sq_y, sq_z;
  logic            merge_ready;
  logic            meas_valid;
  logic            meas_ready;
  sgw_meas_t       meas;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wheel_enable       <= 1'b0;
      cfg.usb_mouse_enable   <= 1'b0;
      cfg.low_enter_level    <= LOW_ENTER_RESET;
      cfg.high_enter_level   <= HIGH_ENTER_RESET;
      cfg.low_recover_level  <= LOW_RECOVER_RESET;
      cfg.high_hold_level    <= HIGH_HOLD_RESET;
      cfg.high_release_level <= HIGH_RELEASE_RESET;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WHEEL_ENABLE:       cfg.wheel_enable       <= cfg_data[0];
        CFG_USB_MOUSE_ENABLE:   cfg.usb_mouse_enable   <= cfg_data[0];
        CFG_LOW_ENTER_LEVEL:    cfg.low_enter_level    <= cfg_data;
        CFG_HIGH_ENTER_LEVEL:   cfg.high_enter_level   <= cfg_data;
        CFG_LOW_RECOVER_LEVEL:  cfg.low_recover_level  <= cfg_data;
        CFG_HIGH_HOLD_LEVEL:    cfg.high_hold_level    <= cfg_data;
        CFG_HIGH_RELEASE_LEVEL: cfg.high_release_level <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign rdy1         = !v1 || merge_ready;
  assign sample.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      host1 <= sample.host_present;
    end
  end

  sgw_square_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk    (clk),
    .load   (rdy1),
    .axis   (sample.accel_x),
    .square (sq_x)
  );

  sgw_square_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk    (clk),
    .load   (rdy1),
    .axis   (sample.accel_y),
    .square (sq_y)
  );

  sgw_square_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
    .clk    (clk),
    .load   (rdy1),
    .axis   (sample.accel_z),
    .square (sq_z)
  );

  sgw_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (v1),
    .in_ready  (merge_ready),
    .in_host   (host1),
    .sq_x      (sq_x),
    .sq_y      (sq_y),
    .sq_z      (sq_z),
    .out_valid (meas_valid),
    .out_ready (meas_ready),
    .meas      (meas)
  );

  sgw_gesture_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (meas_valid),
    .in_ready      (meas_ready),
    .meas          (meas),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .wheel_valid   (result.wheel_valid),
    .wheel_amount  (result.wheel_amount),
    .gesture_phase (result.gesture_phase)
  );

endmodule

// File: rtl/sgw_checker.sv
`timescale 1ns / 1ps
module sgw_checker import sgw_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       wheel_valid,
  input logic signed [AMOUNT_W-1:0] wheel_amount,
  input logic [PHASE_W-1:0]         gesture_phase
);

  // a reported step always carries a nonzero amount, and no step means zero
  a_amount_matches_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wheel_valid == (wheel_amount != '0)))
    else $error("wheel_amount disagrees with wheel_valid");

  a_step_enters_wait: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wheel_valid) |-> (gesture_phase == PHASE_CODE_WAIT))
    else $error("wheel step reported outside the wait phase");

  // the wait window keeps the next result from being another step
  a_no_back_to_back_steps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && wheel_valid) |=> !(out_valid && wheel_valid))
    else $error("two wheel steps in consecutive results");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(wheel_valid)
      && $stable(wheel_amount) && $stable(gesture_phase)))
    else $error("stalled result changed");

  a_reset_empties_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind shake_gesture_wheel_detector_top sgw_checker u_sgw_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .wheel_valid   (result.wheel_valid),
  .wheel_amount  (result.wheel_amount),
  .gesture_phase (result.gesture_phase)
);

// File: tb/wheel_step_checker.sv
`timescale 1ns / 1ps
module wheel_step_checker import sgw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  sgw_sample_if                sample,
  sgw_result_if                result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_data,
  output int                   outstanding,
  output int                   mismatches
);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_LOW         = 3'd1,
    PH_LOW_RECOVER = 3'd2,
    PH_HIGH        = 3'd3,
    PH_WAIT        = 3'd4
  } gesture_phase_e;

  typedef struct packed {
    logic              wheel_valid;
    logic signed [7:0] wheel_amount;
    logic [2:0]        gesture_phase;
  } wheel_step_t;

  localparam int         BASE_MAG       = 1700000;
  localparam int         MAG_PER_UNIT   = 1000000;
  localparam logic [5:0] PEAK_CEIL      = 6'd63;
  localparam logic [6:0] LOW_WINDOW     = 7'd20;
  localparam logic [6:0] RECOVER_WINDOW = 7'd30;
  localparam logic [6:0] WAIT_WINDOW    = 7'd60;
  localparam logic [6:0] HIGH_WINDOW    = 7'd90;
  localparam int         MAX_PRINTED    = 60;

  logic               wheel_on;
  logic               mouse_on;
  logic [LEVEL_W-1:0] low_enter;
  logic [LEVEL_W-1:0] high_enter;
  logic [LEVEL_W-1:0] low_recover;
  logic [LEVEL_W-1:0] high_hold;
  logic [LEVEL_W-1:0] high_release;

  gesture_phase_e phase;
  logic [6:0]     ticks;
  logic [5:0]     peak;
  wheel_step_t    expected_steps[$];
  int             results_seen;

  task automatic report(string what);
    if (mismatches < MAX_PRINTED)
      $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // Keep the largest whole-unit excess over the base magnitude seen so far.
  function automatic void raise_peak(int mag);
    int units;
    if (mag > BASE_MAG) begin
      units = (mag - BASE_MAG) / MAG_PER_UNIT;
      if (units > PEAK_CEIL)
        units = PEAK_CEIL;
      if (units > peak)
        peak = units[5:0];
    end
  endfunction

  function automatic logic [7:0] step_size(logic [5:0] p);
    if (p < 6'd6)
      return 8'd1;
    if (p < 6'd12)
      return 8'd4;
    return {2'b00, p};
  endfunction

  function automatic wheel_step_t advance_gesture(int x, int y, int z, logic host);
    wheel_step_t step;
    int          mag;
    step = '0;
    if (host && mouse_on && wheel_on) begin
      mag = x * x + y * y + z * z;
      case (phase)
        PH_IDLE: begin
          if (mag < low_enter) begin
            phase = PH_LOW;
            peak  = 6'd1;
            ticks = LOW_WINDOW;
          end else if (mag > high_enter) begin
            phase = PH_HIGH;
            peak  = 6'd1;
            ticks = HIGH_WINDOW;
          end
        end
        PH_LOW: begin
          if (mag > low_recover) begin
            phase = PH_LOW_RECOVER;
            ticks = RECOVER_WINDOW;
          end else if (mag < low_enter) begin
            ticks = LOW_WINDOW;
          end
        end
        PH_LOW_RECOVER: begin
          // the step goes out on the last sample of the recovery window
          if (ticks == 7'd1) begin
            step.wheel_valid  = 1'b1;
            step.wheel_amount = -step_size(peak);
            phase = PH_WAIT;
            ticks = WAIT_WINDOW;
          end else begin
            raise_peak(mag);
          end
        end
        PH_HIGH: begin
          if (mag > high_hold) begin
            raise_peak(mag);
          end else if (mag < high_release) begin
            step.wheel_valid  = 1'b1;
            step.wheel_amount = step_size(peak);
            phase = PH_WAIT;
            ticks = WAIT_WINDOW;
          end
        end
        default: ;
      endcase
      if (ticks != 7'd0) begin
        ticks = ticks - 7'd1;
        if (ticks == 7'd0)
          phase = PH_IDLE;
      end
    end
    step.gesture_phase = phase;
    return step;
  endfunction

  always @(posedge clk) begin
    wheel_step_t want;
    if (rst) begin
      wheel_on     = 1'b0;
      mouse_on     = 1'b0;
      low_enter    = 26'd300000;
      high_enter   = 26'd5000000;
      low_recover  = 26'd2000000;
      high_hold    = 26'd3000000;
      high_release = 26'd500000;
      phase        = PH_IDLE;
      ticks        = '0;
      peak         = '0;
      results_seen = 0;
      mismatches   = 0;
      expected_steps.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WHEEL_ENABLE:       wheel_on     = cfg_data[0];
          CFG_USB_MOUSE_ENABLE:   mouse_on     = cfg_data[0];
          CFG_LOW_ENTER_LEVEL:    low_enter    = cfg_data;
          CFG_HIGH_ENTER_LEVEL:   high_enter   = cfg_data;
          CFG_LOW_RECOVER_LEVEL:  low_recover  = cfg_data;
          CFG_HIGH_HOLD_LEVEL:    high_hold    = cfg_data;
          CFG_HIGH_RELEASE_LEVEL: high_release = cfg_data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_steps.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = expected_steps.pop_front();
          if (result.wheel_valid !== want.wheel_valid)
            report($sformatf("wheel_valid %0b, expected %0b",
                             result.wheel_valid, want.wheel_valid));
          if (result.wheel_amount !== want.wheel_amount)
            report($sformatf("wheel_amount %0d, expected %0d",
                             result.wheel_amount, want.wheel_amount));
          if (result.gesture_phase !== want.gesture_phase)
            report($sformatf("gesture_phase %0d, expected %0d",
                             result.gesture_phase, want.gesture_phase));
        end
        results_seen++;
      end
      if (sample.valid && sample.ready)
        expected_steps.push_back(advance_gesture(int'(sample.accel_x), int'(sample.accel_y),
                                                 int'(sample.accel_z), sample.host_present));
      outstanding <= expected_steps.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench import sgw_pkg::*;;

  localparam int                   SAMPLE_BITS      = 13;
  localparam int                   ITEM_GOAL        = 1350;
  localparam int                   CYCLE_LIMIT      = 600000;
  localparam int                   SETTLE_CYCLES    = 10;
  localparam int unsigned          AXIS_MAX         = 4095;
  localparam int unsigned          MAG_TOP          = 3 * 4095 * 4095;
  localparam logic [LEVEL_W-1:0]   LEVEL_MAX        = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

  typedef enum {
    BAND_DIP, BAND_REST, BAND_RECOVER, BAND_SPIKE, BAND_RELEASE,
    BAND_LINGER_LOW, BAND_LINGER_HIGH, BAND_ANY
  } band_e;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } accel_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]   cfg_data;
  int                   outstanding;
  int                   mismatches;
  int                   cycle_count;

  bit          rush;
  logic        wheel_on;
  logic        mouse_on;
  int unsigned lvl_low_enter;
  int unsigned lvl_high_enter;
  int unsigned lvl_low_recover;
  int unsigned lvl_high_hold;
  int unsigned lvl_high_release;
  int          active_items;

  sgw_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  sgw_result_if result_ch ();

  shake_gesture_wheel_detector_top #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wheel_step_checker gesture_check (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_ch),
    .result      (result_ch),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned axis_root(int unsigned v);
    int unsigned r;
    int unsigned b;
    r = 0;
    for (int i = 15; i >= 0; i--) begin
      b = r | (32'd1 << i);
      if (b * b <= v)
        r = b;
    end
    return (r > AXIS_MAX) ? AXIS_MAX : r;
  endfunction

  function automatic int unsigned span(int unsigned lo, int unsigned hi);
    int unsigned t;
    if (lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    if (hi > MAG_TOP)
      hi = MAG_TOP;
    if (lo > hi)
      lo = hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int unsigned band_level(band_e band);
    case (band)
      BAND_DIP:         return span(0, (lvl_low_enter == 0) ? 0 : lvl_low_enter - 1);
      BAND_REST:        return span(lvl_low_enter, lvl_high_enter);
      BAND_RECOVER:     return span(lvl_low_recover + 1, MAG_TOP);
      BAND_SPIKE:       return span(lvl_high_enter + 1, MAG_TOP);
      BAND_RELEASE:     return span(0, (lvl_high_release == 0) ? 0 : lvl_high_release - 1);
      BAND_LINGER_LOW:  return span(lvl_low_enter, lvl_low_recover);
      BAND_LINGER_HIGH: return span(lvl_high_release, lvl_high_hold);
      default:          return span(0, MAG_TOP);
    endcase
  endfunction

  function automatic accel_t make_accel(int x, int y, int z);
    accel_t s;
    s.x = SAMPLE_BITS'(x);
    s.y = SAMPLE_BITS'(y);
    s.z = SAMPLE_BITS'(z);
    return s;
  endfunction

  // Build a sample whose squared magnitude lands at or under the target.
  task automatic shape(input int unsigned target, output accel_t s);
    int unsigned rest;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int          axis[3];
    int          r;
    rest = (target > MAG_TOP) ? MAG_TOP : target;
    a = $urandom_range(axis_root(rest / 3), 0);
    rest -= a * a;
    b = $urandom_range(axis_root(rest / 2), 0);
    rest -= b * b;
    c = axis_root(rest);
    axis[0] = $urandom_range(0, 1) ? -int'(a) : int'(a);
    axis[1] = $urandom_range(0, 1) ? -int'(b) : int'(b);
    axis[2] = $urandom_range(0, 1) ? -int'(c) : int'(c);
    r = $urandom_range(0, 2);
    s = make_accel(axis[r], axis[(r + 1) % 3], axis[(r + 2) % 3]);
  endtask

  task automatic send_sample(accel_t s, logic host);
    int unsigned gap;
    gap = rush ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.accel_x      <= s.x;
    sample_ch.accel_y      <= s.y;
    sample_ch.accel_z      <= s.z;
    sample_ch.host_present <= host;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (host && wheel_on && mouse_on)
      active_items++;
  endtask

  task automatic send_band(band_e band);
    accel_t s;
    shape(band_level(band), s);
    send_sample(s, $urandom_range(0, 15) != 0);
  endtask

  task automatic send_noise();
    accel_t s;
    s.x = SAMPLE_BITS'($urandom());
    s.y = SAMPLE_BITS'($urandom());
    s.z = SAMPLE_BITS'($urandom());
    send_sample(s, $urandom_range(0, 9) != 0);
  endtask

  // Drop valid and hold until every predicted result has been transferred.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are junk on purpose: only bit 0 of an enable counts.
  task automatic set_enables(logic w, logic u);
    settle();
    write_reg(CFG_WHEEL_ENABLE, {25'($urandom()), w});
    write_reg(CFG_USB_MOUSE_ENABLE, {25'($urandom()), u});
    wheel_on = w;
    mouse_on = u;
  endtask

  task automatic set_levels(int unsigned le, int unsigned he, int unsigned lr,
                            int unsigned hh, int unsigned hr);
    settle();
    write_reg(CFG_LOW_ENTER_LEVEL, LEVEL_W'(le));
    write_reg(CFG_HIGH_ENTER_LEVEL, LEVEL_W'(he));
    write_reg(CFG_LOW_RECOVER_LEVEL, LEVEL_W'(lr));
    write_reg(CFG_HIGH_HOLD_LEVEL, LEVEL_W'(hh));
    write_reg(CFG_HIGH_RELEASE_LEVEL, LEVEL_W'(hr));
    lvl_low_enter    = le;
    lvl_high_enter   = he;
    lvl_low_recover  = lr;
    lvl_high_hold    = hh;
    lvl_high_release = hr;
  endtask

  task automatic run_gesture();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    rush = ($urandom_range(0, 4) == 0);
    if (kind < 4) begin
      // dip, then either recover or let the low window time out
      repeat ($urandom_range(0, 3)) send_band(BAND_REST);
      repeat ($urandom_range(1, 4)) send_band(BAND_DIP);
      if ($urandom_range(0, 3) == 0) begin
        repeat (22) send_band(BAND_LINGER_LOW);
      end else begin
        send_band(BAND_RECOVER);
        repeat (30) send_band(BAND_ANY);
      end
      repeat ($urandom_range(40, 62)) send_noise();
    end else if (kind < 8) begin
      // spike, then either release or hold until the high window runs out
      repeat ($urandom_range(0, 2)) send_band(BAND_REST);
      send_band(BAND_SPIKE);
      repeat ($urandom_range(0, 6))
        send_band($urandom_range(0, 1) ? BAND_SPIKE : BAND_LINGER_HIGH);
      if ($urandom_range(0, 3) == 0)
        repeat (92) send_band(BAND_LINGER_HIGH);
      else
        send_band(BAND_RELEASE);
      repeat ($urandom_range(40, 62)) send_noise();
    end else begin
      repeat ($urandom_range(5, 30)) send_noise();
    end
  endtask

  initial begin
    int goal;
    rst                    <= 1'b1;
    cfg_write              <= 1'b0;
    cfg_index              <= CFG_WHEEL_ENABLE;
    cfg_data               <= '0;
    sample_ch.valid        <= 1'b0;
    sample_ch.accel_x      <= '0;
    sample_ch.accel_y      <= '0;
    sample_ch.accel_z      <= '0;
    sample_ch.host_present <= 1'b0;
    cycle_count            <= 0;
    rush             = 1'b0;
    wheel_on         = 1'b0;
    mouse_on         = 1'b0;
    lvl_low_enter    = LOW_ENTER_RESET;
    lvl_high_enter   = HIGH_ENTER_RESET;
    lvl_low_recover  = LOW_RECOVER_RESET;
    lvl_high_hold    = HIGH_HOLD_RESET;
    lvl_high_release = HIGH_RELEASE_RESET;
    active_items     = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // enable combinations: nothing should move until both are on
    send_sample(make_accel(4095, 4095, 4095), 1'b1);
    set_enables(1'b0, 1'b1);
    send_sample(make_accel(0, 0, 0), 1'b1);
    set_enables(1'b1, 1'b0);
    send_sample(make_accel(-4096, 0, 0), 1'b1);
    set_enables(1'b1, 1'b1);
    send_sample(make_accel(-4096, -4096, -4096), 1'b0);
    // spike: enter, raise peak, sit exactly on the excess base, drive the largest magnitude, release
    send_sample(make_accel(2600, 0, 0), 1'b1);
    send_sample(make_accel(3750, 0, 0), 1'b1);
    send_sample(make_accel(1300, 100, 0), 1'b1);
    send_sample(make_accel(-4096, -4096, -4096), 1'b1);
    send_sample(make_accel(0, 0, 0), 1'b1);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: ;
        1: set_levels(0, 0, 0, 0, 0);
        2: set_levels(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        3: begin
          set_levels($urandom_range(0, 2000000), $urandom_range(2000000, 20000000),
                     $urandom_range(500000, 8000000), $urandom_range(1000000, 20000000),
                     $urandom_range(0, 3000000));
          write_reg(CFG_UNUSED_INDEX, LEVEL_W'($urandom()));
        end
        4: set_levels($urandom_range(0, 1000000), $urandom_range(3000000, 12000000),
                      $urandom_range(1000000, 4000000), $urandom_range(2000000, 6000000),
                      $urandom_range(100000, 1500000));
        default: set_levels(LOW_ENTER_RESET, HIGH_ENTER_RESET, LOW_RECOVER_RESET,
                            HIGH_HOLD_RESET, HIGH_RELEASE_RESET);
      endcase
      goal = (p + 1) * ITEM_GOAL / 6;
      while (active_items < goal) begin
        if (p == 4 && $urandom_range(0, 7) == 0) begin
          set_enables(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          repeat ($urandom_range(5, 20)) send_noise();
          set_enables(1'b1, 1'b1);
        end
        run_gesture();
      end
    end

    settle();
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // result side: random stall before each transfer, none while rushing
  initial begin
    int unsigned stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = rush ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

endmodule
